@@ sv/ivn_pkg.sv @@
// Shared types and constants for the IMU vector normalizer.
package ivn_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned SUMSQ_W = 32;
   localparam int unsigned ROOT_W = 16;
   localparam int unsigned QUO_W = 15;
   localparam int unsigned SCALE_W = 24;
   localparam int unsigned RATE_W = 32;
   localparam int unsigned ROOT_CELLS = 16;
   localparam int unsigned DIV_CELLS = 15;
   localparam int unsigned LATENCY = 34;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd17852;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic signed [SAMPLE_W-1:0] gyro_x;
      logic signed [SAMPLE_W-1:0] gyro_y;
      logic signed [SAMPLE_W-1:0] gyro_z;
      logic signed [SAMPLE_W-1:0] mag_x;
      logic signed [SAMPLE_W-1:0] mag_y;
      logic signed [SAMPLE_W-1:0] mag_z;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x_unit;
      logic signed [SAMPLE_W-1:0] accel_y_unit;
      logic signed [SAMPLE_W-1:0] accel_z_unit;
      logic signed [RATE_W-1:0]   rate_x;
      logic signed [RATE_W-1:0]   rate_y;
      logic signed [RATE_W-1:0]   rate_z;
      logic signed [SAMPLE_W-1:0] mag_x_unit;
      logic signed [SAMPLE_W-1:0] mag_y_unit;
      logic signed [SAMPLE_W-1:0] mag_z_unit;
      logic                       accel_zero;
      logic                       mag_zero;
   } rsp_word_type;

   // magnitudes and sign flags of one vector riding the chain
   typedef struct packed {
      logic [SAMPLE_W:0] mag_x;
      logic [SAMPLE_W:0] mag_y;
      logic [SAMPLE_W:0] mag_z;
      logic              neg_x;
      logic              neg_y;
      logic              neg_z;
   } vec_type;

   // rounded gyro rates riding the chain
   typedef struct packed {
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
      logic signed [RATE_W-1:0] rate_z;
   } rate_type;

   // square root cell state
   typedef struct packed {
      logic [SUMSQ_W-1:0] rem;
      logic [ROOT_W-1:0]  root;
   } root_type;

   // divide cell state for one component
   typedef struct packed {
      logic [ROOT_W+1:0]  rem;
      logic [SAMPLE_W:0]  num;
      logic [QUO_W-1:0]   quo;
   } div_type;

endpackage

@@ sv/ivn_root_cell.sv @@
// One restoring square root step: settles one root bit per cell.
module ivn_root_cell #(
   parameter int unsigned STEP = 0
) (
   input  ivn_pkg::root_type  in_state,
   output ivn_pkg::root_type  out_state
);

   localparam int unsigned SHIFT = 2 * (ivn_pkg::ROOT_W - 1 - STEP);

   logic [ivn_pkg::SUMSQ_W+1:0] trial;
   logic [ivn_pkg::SUMSQ_W+1:0] rem_wide;

   always_comb begin
      trial = ({2'b00, ivn_pkg::SUMSQ_W'(in_state.root)} << (ivn_pkg::ROOT_W - STEP))
            | ((ivn_pkg::SUMSQ_W + 2)'(1) << SHIFT);
      rem_wide = {2'b00, in_state.rem};
      if (rem_wide >= trial) begin
         out_state.rem = ivn_pkg::SUMSQ_W'(rem_wide - trial);
         out_state.root = in_state.root
                        | (ivn_pkg::ROOT_W'(1) << (ivn_pkg::ROOT_W - 1 - STEP));
      end else begin
         out_state = in_state;
      end
   end

endmodule

@@ sv/ivn_div_cell.sv @@
// One restoring divide step: settles one quotient bit per cell.
module ivn_div_cell (
   input  logic [ivn_pkg::ROOT_W:0] divisor,
   input  ivn_pkg::div_type         in_state,
   output ivn_pkg::div_type         out_state
);

   logic [ivn_pkg::ROOT_W+2:0] shifted;

   always_comb begin
      shifted = {in_state.rem, in_state.num[ivn_pkg::SAMPLE_W]};
      out_state.num = {in_state.num[ivn_pkg::SAMPLE_W-1:0], 1'b0};
      if (shifted >= {2'b00, divisor}) begin
         out_state.rem = (ivn_pkg::ROOT_W + 2)'(shifted - {2'b00, divisor});
         out_state.quo = {in_state.quo[ivn_pkg::QUO_W-2:0], 1'b1};
      end else begin
         out_state.rem = shifted[ivn_pkg::ROOT_W+1:0];
         out_state.quo = {in_state.quo[ivn_pkg::QUO_W-2:0], 1'b0};
      end
   end

endmodule

@@ sv/ivn_normalizer.sv @@
// One vector: sum of squares, square root chain, divide chain, rounding.
module ivn_normalizer (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [ivn_pkg::SAMPLE_W-1:0] in_x,
   input  logic signed [ivn_pkg::SAMPLE_W-1:0] in_y,
   input  logic signed [ivn_pkg::SAMPLE_W-1:0] in_z,
   input  logic                              neg_x,
   output logic signed [ivn_pkg::SAMPLE_W-1:0] out_x,
   output logic signed [ivn_pkg::SAMPLE_W-1:0] out_y,
   output logic signed [ivn_pkg::SAMPLE_W-1:0] out_z,
   output logic                              out_zero
);

   localparam int unsigned RC = ivn_pkg::ROOT_CELLS;
   localparam int unsigned DC = ivn_pkg::DIV_CELLS;
   localparam int unsigned SW = ivn_pkg::SAMPLE_W;
   localparam int unsigned RW = ivn_pkg::ROOT_W;

   // stage 0: magnitudes and squares
   ivn_pkg::vec_type               vec0_ff, vec0_in;
   logic [2*SW+1:0]                sq_x_ff, sq_y_ff, sq_z_ff;
   // stage 1: sum
   ivn_pkg::vec_type               vec1_ff;
   logic [ivn_pkg::SUMSQ_W-1:0]    sum_ff;

   ivn_pkg::root_type              root_at [RC];
   ivn_pkg::root_type              root_in [RC];
   ivn_pkg::root_type              root_ff [RC];
   ivn_pkg::vec_type               rvec_ff [RC];

   // divide |v| * 2^15 by 2*len, remainder seeded with |v|
   logic [RW:0]                    dvs_at [DC];
   logic [RW:0]                    dvs_ff [DC];
   ivn_pkg::div_type               dx_at [DC], dy_at [DC], dz_at [DC];
   ivn_pkg::div_type               dx_in [DC], dy_in [DC], dz_in [DC];
   ivn_pkg::div_type               dx_ff [DC], dy_ff [DC], dz_ff [DC];
   logic [2:0]                     sgn_ff [DC];
   logic                           zero_ff [DC];

   logic [SW:0]                    ax, ay, az;
   logic [SW-1:0]                  ox, oy, oz;
   logic                           unused_ok;

   always_comb begin
      ax = in_x[SW-1] ? (SW+1)'(-{in_x[SW-1], in_x}) : {1'b0, in_x};
      ay = in_y[SW-1] ? (SW+1)'(-{in_y[SW-1], in_y}) : {1'b0, in_y};
      az = in_z[SW-1] ? (SW+1)'(-{in_z[SW-1], in_z}) : {1'b0, in_z};
      vec0_in.mag_x = ax;
      vec0_in.mag_y = ay;
      vec0_in.mag_z = az;
      vec0_in.neg_x = in_x[SW-1] ^ neg_x;
      vec0_in.neg_y = in_y[SW-1];
      vec0_in.neg_z = in_z[SW-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec0_ff <= vec0_in;
         sq_x_ff <= ax * ax;
         sq_y_ff <= ay * ay;
         sq_z_ff <= az * az;
         vec1_ff <= vec0_ff;
         sum_ff <= ivn_pkg::SUMSQ_W'(sq_x_ff + sq_y_ff + sq_z_ff);
      end
   end

   always_comb begin
      root_at[0] = '{rem: sum_ff, root: '0};
      for (int k = 1; k < RC; k++) root_at[k] = root_ff[k-1];
   end

   for (genvar i = 0; i < RC; i++) begin : g_root
      ivn_root_cell #(.STEP(i)) u_cell (
         .in_state  (root_at[i]),
         .out_state (root_in[i])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rvec_ff[0] <= vec1_ff;
         for (int k = 0; k < RC; k++) root_ff[k] <= root_in[k];
         for (int k = 1; k < RC; k++) rvec_ff[k] <= rvec_ff[k-1];
      end
   end

   always_comb begin
      dvs_at[0] = {root_ff[RC-1].root, 1'b0};
      dx_at[0] = '{rem: {1'b0, rvec_ff[RC-1].mag_x}, num: '0, quo: '0};
      dy_at[0] = '{rem: {1'b0, rvec_ff[RC-1].mag_y}, num: '0, quo: '0};
      dz_at[0] = '{rem: {1'b0, rvec_ff[RC-1].mag_z}, num: '0, quo: '0};
      for (int k = 1; k < DC; k++) begin
         dvs_at[k] = dvs_ff[k-1];
         dx_at[k] = dx_ff[k-1];
         dy_at[k] = dy_ff[k-1];
         dz_at[k] = dz_ff[k-1];
      end
   end

   for (genvar j = 0; j < DC; j++) begin : g_div
      ivn_div_cell u_dx (.divisor(dvs_at[j]), .in_state(dx_at[j]), .out_state(dx_in[j]));
      ivn_div_cell u_dy (.divisor(dvs_at[j]), .in_state(dy_at[j]), .out_state(dy_in[j]));
      ivn_div_cell u_dz (.divisor(dvs_at[j]), .in_state(dz_at[j]), .out_state(dz_in[j]));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sgn_ff[0] <= {rvec_ff[RC-1].neg_x, rvec_ff[RC-1].neg_y, rvec_ff[RC-1].neg_z};
         zero_ff[0] <= (root_ff[RC-1].root == '0);
         for (int k = 0; k < DC; k++) begin
            dvs_ff[k] <= dvs_at[k];
            dx_ff[k] <= dx_in[k];
            dy_ff[k] <= dy_in[k];
            dz_ff[k] <= dz_in[k];
         end
         for (int k = 1; k < DC; k++) begin
            sgn_ff[k] <= sgn_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   // round up when the remainder reaches len
   function automatic logic [SW-1:0] finish(input ivn_pkg::div_type d,
                                            input logic [RW:0] dv,
                                            input logic sg, input logic z);
      logic [SW-1:0] m;
      logic [RW+1:0] r2;
      begin
         r2 = {d.rem[RW:0], 1'b0};
         m = {1'b0, d.quo} + ((r2 >= {1'b0, dv}) ? SW'(1) : SW'(0));
         finish = z ? '0 : (sg ? SW'(-m) : m);
      end
   endfunction

   always_comb begin
      ox = finish(dx_ff[DC-1], dvs_ff[DC-1], sgn_ff[DC-1][2], zero_ff[DC-1]);
      oy = finish(dy_ff[DC-1], dvs_ff[DC-1], sgn_ff[DC-1][1], zero_ff[DC-1]);
      oz = finish(dz_ff[DC-1], dvs_ff[DC-1], sgn_ff[DC-1][0], zero_ff[DC-1]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x <= ox;
         out_y <= oy;
         out_z <= oz;
         out_zero <= zero_ff[DC-1];
      end
   end

   assign unused_ok = ^{dx_ff[DC-1].num, dy_ff[DC-1].num, dz_ff[DC-1].num,
                        dx_ff[DC-1].rem[RW+1], dy_ff[DC-1].rem[RW+1],
                        dz_ff[DC-1].rem[RW+1]};

endmodule

@@ sv/imu_vector_normalizer_core.sv @@
// Top level of the IMU vector normalizer.
// An item passes through two register stages for the sum of squares,
// sixteen square root cells, fifteen divide cells and the rounding
// register, and one item is accepted every cycle while the chain is not
// stalled. The whole chain advances together: while the result
// register is stalled the chain holds and the input stalls, so the input
// side sees stall only while a finished result waits.
module imu_vector_normalizer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ivn_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ivn_pkg::rsp_word_type rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ivn_pkg::SCALE_W-1:0] csr_data
);

   localparam int unsigned RW = ivn_pkg::RATE_W;
   localparam int unsigned LATENCY = ivn_pkg::LATENCY;
   localparam int unsigned SW = ivn_pkg::SAMPLE_W;

   logic [ivn_pkg::SCALE_W-1:0] scale_ff;
   logic [LATENCY-1:0]          vld_ff, vld_in;
   logic                        advance;
   ivn_pkg::rate_type           rate_ff [LATENCY];
   ivn_pkg::rate_type           rate_in;
   logic signed [SW-1:0]        accel_x_unit, accel_y_unit, accel_z_unit;
   logic signed [SW-1:0]        mag_x_unit, mag_y_unit, mag_z_unit;
   logic                        accel_zero, mag_zero;

   assign advance = !(vld_ff[LATENCY-1] && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[LATENCY-1];

   always_comb begin
      vld_in = {vld_ff[LATENCY-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         scale_ff <= ivn_pkg::SCALE_RESET;
      end else begin
         if (advance) vld_ff <= vld_in;
         if (csr_valid) scale_ff <= csr_data;
      end
   end

   function automatic logic signed [RW-1:0] scale_rate(
         input logic signed [ivn_pkg::SAMPLE_W-1:0] g,
         input logic [ivn_pkg::SCALE_W-1:0] s, input logic neg);
      logic [ivn_pkg::SAMPLE_W:0] a;
      logic [ivn_pkg::SAMPLE_W+ivn_pkg::SCALE_W:0] p;
      logic [RW-1:0] m;
      begin
         a = g[ivn_pkg::SAMPLE_W-1] ? (ivn_pkg::SAMPLE_W+1)'(-{g[ivn_pkg::SAMPLE_W-1], g})
                                    : {1'b0, g};
         p = a * s + (ivn_pkg::SAMPLE_W+ivn_pkg::SCALE_W+1)'(128);
         m = RW'(p >> 8);
         scale_rate = (g[ivn_pkg::SAMPLE_W-1] ^ neg) ? RW'(-m) : m;
      end
   endfunction

   always_comb begin
      rate_in.rate_x = scale_rate(req_word.gyro_x, scale_ff, 1'b0);
      rate_in.rate_y = scale_rate(req_word.gyro_y, scale_ff, 1'b1);
      rate_in.rate_z = scale_rate(req_word.gyro_z, scale_ff, 1'b1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rate_ff[0] <= rate_in;
         for (int k = 1; k < LATENCY; k++) rate_ff[k] <= rate_ff[k-1];
      end
   end

   ivn_normalizer u_accel (
      .clock (clock), .advance (advance),
      .in_x (req_word.accel_x), .in_y (req_word.accel_y), .in_z (req_word.accel_z),
      .neg_x (1'b1),
      .out_x (accel_x_unit), .out_y (accel_y_unit),
      .out_z (accel_z_unit), .out_zero (accel_zero)
   );

   ivn_normalizer u_mag (
      .clock (clock), .advance (advance),
      .in_x (req_word.mag_x), .in_y (req_word.mag_y), .in_z (req_word.mag_z),
      .neg_x (1'b0),
      .out_x (mag_x_unit), .out_y (mag_y_unit),
      .out_z (mag_z_unit), .out_zero (mag_zero)
   );

   always_comb begin
      rsp_word.accel_x_unit = accel_x_unit;
      rsp_word.accel_y_unit = accel_y_unit;
      rsp_word.accel_z_unit = accel_z_unit;
      rsp_word.rate_x = rate_ff[LATENCY-1].rate_x;
      rsp_word.rate_y = rate_ff[LATENCY-1].rate_y;
      rsp_word.rate_z = rate_ff[LATENCY-1].rate_z;
      rsp_word.mag_x_unit = mag_x_unit;
      rsp_word.mag_y_unit = mag_y_unit;
      rsp_word.mag_z_unit = mag_z_unit;
      rsp_word.accel_zero = accel_zero;
      rsp_word.mag_zero = mag_zero;
   end

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("stall without waiting word");
   a_hold_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("waiting word lost");
   a_zero_units: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.accel_zero |-> rsp_word.accel_x_unit == '0)
      else $error("zero vector gave nonzero unit");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the IMU vector normalizer: directed table, then random words.
`timescale 1ns / 1ps
module testbench;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   ivn_pkg::req_word_type         req_word = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   ivn_pkg::rsp_word_type         rsp_word;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [ivn_pkg::SCALE_W-1:0]   csr_data = '0;

   imu_vector_normalizer_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [ivn_pkg::SCALE_W-1:0] scale_now;
   ivn_pkg::rsp_word_type       pending_rsp[$];
   int                          mismatch_count = 0;
   int                          send_idle_pct = 0;
   int                          recv_stall_pct = 0;
   int                          hold_cycles = 0;

   typedef struct {
      ivn_pkg::req_word_type word;
      logic                  has_fixed;
      ivn_pkg::rsp_word_type fixed;
   } stim_row_type;

   stim_row_type stim_rows[$];

   function automatic logic [31:0] root_floor(logic [31:0] n);
      logic [31:0] root;
      logic [31:0] bitv;
      root = 0;
      bitv = 32'h4000_0000;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [15:0] unit_part(logic signed [15:0] v, logic [31:0] len,
                                             logic flip);
      logic [63:0] mag;
      logic [16:0] av;
      av = (v < 0) ? 17'(-int'(v)) : 17'(v);
      mag = (64'(av) * 64'd32768 + 64'(len)) / (64'd2 * 64'(len));
      return (((v < 0) != flip) ? 16'(-mag) : 16'(mag));
   endfunction

   function automatic void unit_vector(logic signed [15:0] x, logic signed [15:0] y,
                                       logic signed [15:0] z, logic flip_x,
                                       output logic [15:0] ox, output logic [15:0] oy,
                                       output logic [15:0] oz, output logic zero);
      logic [31:0] sum;
      logic [31:0] len;
      sum = 32'(int'(x) * int'(x)) + 32'(int'(y) * int'(y)) + 32'(int'(z) * int'(z));
      len = root_floor(sum);
      zero = (len == 0);
      if (zero) begin
         ox = 0; oy = 0; oz = 0;
      end else begin
         ox = unit_part(x, len, flip_x);
         oy = unit_part(y, len, 1'b0);
         oz = unit_part(z, len, 1'b0);
      end
   endfunction

   function automatic logic [31:0] scaled_rate(logic signed [15:0] g, logic flip);
      logic [63:0] mag;
      logic [16:0] ag;
      ag = (g < 0) ? 17'(-int'(g)) : 17'(g);
      mag = (64'(ag) * 64'(scale_now) + 64'd128) >> 8;
      return (((g < 0) != flip) ? 32'(-mag) : 32'(mag));
   endfunction

   function automatic ivn_pkg::rsp_word_type normalize_word(ivn_pkg::req_word_type w);
      ivn_pkg::rsp_word_type r;
      logic [15:0] ux, uy, uz;
      logic z;
      unit_vector(w.accel_x, w.accel_y, w.accel_z, 1'b1, ux, uy, uz, z);
      r.accel_x_unit = ux; r.accel_y_unit = uy; r.accel_z_unit = uz; r.accel_zero = z;
      unit_vector(w.mag_x, w.mag_y, w.mag_z, 1'b0, ux, uy, uz, z);
      r.mag_x_unit = ux; r.mag_y_unit = uy; r.mag_z_unit = uz; r.mag_zero = z;
      r.rate_x = scaled_rate(w.gyro_x, 1'b0);
      r.rate_y = scaled_rate(w.gyro_y, 1'b1);
      r.rate_z = scaled_rate(w.gyro_z, 1'b1);
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
      mismatch_count++;
   endtask

   // compare and retire
   always @(posedge clock) begin
      ivn_pkg::rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_word.accel_x_unit !== e.accel_x_unit)
               report_mismatch("accel_x_unit", rsp_word.accel_x_unit, e.accel_x_unit);
            if (rsp_word.accel_y_unit !== e.accel_y_unit)
               report_mismatch("accel_y_unit", rsp_word.accel_y_unit, e.accel_y_unit);
            if (rsp_word.accel_z_unit !== e.accel_z_unit)
               report_mismatch("accel_z_unit", rsp_word.accel_z_unit, e.accel_z_unit);
            if (rsp_word.rate_x !== e.rate_x)
               report_mismatch("rate_x", rsp_word.rate_x, e.rate_x);
            if (rsp_word.rate_y !== e.rate_y)
               report_mismatch("rate_y", rsp_word.rate_y, e.rate_y);
            if (rsp_word.rate_z !== e.rate_z)
               report_mismatch("rate_z", rsp_word.rate_z, e.rate_z);
            if (rsp_word.mag_x_unit !== e.mag_x_unit)
               report_mismatch("mag_x_unit", rsp_word.mag_x_unit, e.mag_x_unit);
            if (rsp_word.mag_y_unit !== e.mag_y_unit)
               report_mismatch("mag_y_unit", rsp_word.mag_y_unit, e.mag_y_unit);
            if (rsp_word.mag_z_unit !== e.mag_z_unit)
               report_mismatch("mag_z_unit", rsp_word.mag_z_unit, e.mag_z_unit);
            if (rsp_word.accel_zero !== e.accel_zero)
               report_mismatch("accel_zero", rsp_word.accel_zero, e.accel_zero);
            if (rsp_word.mag_zero !== e.mag_zero)
               report_mismatch("mag_zero", rsp_word.mag_zero, e.mag_zero);
         end
      end
   end

   // receiver stall, with an optional long hold
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic write_scale(logic [ivn_pkg::SCALE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      scale_now = value;
   endtask

   task automatic drain_block();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (ivn_pkg::LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_word(ivn_pkg::req_word_type w, logic has_fixed,
                            ivn_pkg::rsp_word_type fixed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      pending_rsp.push_back(has_fixed ? fixed : normalize_word(w));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(int'($urandom_range(8)) - 4);
         3: return 16'(int'($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic ivn_pkg::req_word_type rand_word();
      ivn_pkg::req_word_type w;
      w.accel_x = rand_sample(); w.accel_y = rand_sample(); w.accel_z = rand_sample();
      w.gyro_x = rand_sample(); w.gyro_y = rand_sample(); w.gyro_z = rand_sample();
      w.mag_x = rand_sample(); w.mag_y = rand_sample(); w.mag_z = rand_sample();
      if ($urandom_range(19) == 0) begin
         w.accel_x = 0; w.accel_y = 0; w.accel_z = 0;
      end
      if ($urandom_range(19) == 0) begin
         w.mag_x = 0; w.mag_y = 0; w.mag_z = 0;
      end
      return w;
   endfunction

   task automatic add_row(ivn_pkg::req_word_type w, logic has_fixed,
                          ivn_pkg::rsp_word_type fixed);
      stim_row_type r;
      r.word = w;
      r.has_fixed = has_fixed;
      r.fixed = fixed;
      stim_rows.push_back(r);
   endtask

   initial begin
      ivn_pkg::req_word_type w;
      ivn_pkg::rsp_word_type f;
      logic [ivn_pkg::SCALE_W-1:0] scale_set[6];
      scale_now = ivn_pkg::SCALE_RESET;
      scale_set = '{24'hFFFFFF, 24'd0, 24'd1, 24'd256, 24'h800000, 24'd17852};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all zero: both flags, zero rates
      w = '0; f = '0; f.accel_zero = 1'b1; f.mag_zero = 1'b1;
      add_row(w, 1'b1, f);
      // unit axes
      w = '0; w.accel_x = 16'sd100; w.mag_z = -16'sd5;
      f = '0; f.accel_x_unit = -16'sd16384; f.mag_z_unit = -16'sd16384;
      add_row(w, 1'b1, f);
      w = '0; w.accel_x = 16'sh8000; w.mag_y = 16'sh8000; w.gyro_x = 16'sd256;
      f = '0; f.accel_x_unit = 16'sd16384; f.mag_y_unit = -16'sd16384;
      f.rate_x = 32'sd17852;
      add_row(w, 1'b1, f);
      w = '{default: 16'sh8000}; add_row(w, 1'b0, f);
      w = '{default: 16'sh7FFF}; add_row(w, 1'b0, f);
      w = '{default: 16'sh0001}; add_row(w, 1'b0, f);
      w = '{default: 16'shFFFF}; add_row(w, 1'b0, f);
      w = '{16'sd3, -16'sd4, 16'sd0, -16'sd1, 16'sd1, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1};
      add_row(w, 1'b0, f);
      w = '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd2, 16'sd2, 16'sd1};
      add_row(w, 1'b0, f);
      for (int i = 0; i < stim_rows.size(); i++)
         send_word(stim_rows[i].word, stim_rows[i].has_fixed, stim_rows[i].fixed);
      req_valid <= 1'b0;
      drain_block();

      for (int ph = 0; ph < 6; ph++) begin
         write_scale(scale_set[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 70; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 70; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         if (ph == 0) hold_cycles = 120;
         for (int n = 0; n < 225; n++) begin
            send_word(rand_word(), 1'b0, f);
            if (n == 100) begin
               req_valid <= 1'b0;
               while (pending_rsp.size() != 0) @(posedge clock);
            end
         end
         req_valid <= 1'b0;
         drain_block();
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
